[sv/hkrb_pkg.sv]
// Package: shared types, constants and the ASCII usage table of the report builder.
`default_nettype none

package hkrb_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

    localparam logic [7:0] RAW_BASE   = 8'd136;
    localparam logic [7:0] MOD_BASE   = 8'd128;
    localparam logic [7:0] LEFT_SHIFT = 8'h02;
    localparam logic [7:0] USAGE_MASK = 8'h7F;
    localparam logic [7:0] SHIFT_FLAG = 8'h80;

    typedef enum logic [1:0] {
        OP_PRESS       = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2,
        OP_UNUSED      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    // ASCII code to usage; bit 7 adds left shift, zero means unmapped.
    localparam logic [7:0] ASCII_ROM [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

endpackage

`default_nettype wire

[sv/hkrb_if.sv]
// Interfaces: key event request channel and report response channel.
`default_nettype none

interface hkrb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] key_code;

    modport source (output valid, opcode, key_code, input ready);
    modport sink   (input valid, opcode, key_code, output ready);
endinterface

interface hkrb_rpt_if;
    logic       valid;
    logic       ready;
    logic       report_sent;
    logic       accepted;
    logic [7:0] modifier_bits;
    logic [7:0] slot_zero;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
    logic       error_flag;

    modport source (output valid, report_sent, accepted, modifier_bits, slot_zero,
                    slot_one, slot_two, slot_three, slot_four, slot_five, error_flag,
                    input ready);
    modport sink   (input valid, report_sent, accepted, modifier_bits, slot_zero,
                    slot_one, slot_two, slot_three, slot_four, slot_five, error_flag,
                    output ready);
endinterface

`default_nettype wire

[sv/hid_keyboard_report_builder_core.sv]
// Top level: HID boot keyboard report builder with six-key rollover.
`default_nettype none

// Keeps one boot keyboard report (modifier byte plus six key slots) and
// applies one key event request at a time: press, release or release all.
// Each request yields exactly one response carrying the whole report after
// the event, a report_sent and an accepted flag, and the sticky error flag,
// which only reset clears. The controller steps each request through capture,
// update and present; the next request is taken only once the response has
// been taken, so a stalled response stalls the request side.
module hid_keyboard_report_builder_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hkrb_req_if.sink    req,
    hkrb_rpt_if.source  rsp
);

    hkrb_pkg::cmd_t cmd;
    logic [7:0]     slots [hkrb_pkg::NUM_SLOTS];

    // Controller: owns both handshakes and issues load and update commands.
    hkrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rpt_valid (rsp.valid),
        .rpt_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath: decode, slot search and report state.
    hkrb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (req.opcode),
        .key_code      (req.key_code),
        .report_sent   (rsp.report_sent),
        .accepted      (rsp.accepted),
        .modifier_bits (rsp.modifier_bits),
        .slots         (slots),
        .error_flag    (rsp.error_flag)
    );

    // Present the slots under their report field names.
    assign rsp.slot_zero  = slots[0];
    assign rsp.slot_one   = slots[1];
    assign rsp.slot_two   = slots[2];
    assign rsp.slot_three = slots[3];
    assign rsp.slot_four  = slots[4];
    assign rsp.slot_five  = slots[5];

endmodule

`default_nettype wire

[sv/hkrb_ctrl.sv]
// Controller: sequences capture, update and presentation of one request.
`default_nettype none

module hkrb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rpt_valid,
    input  wire logic          rpt_ready,
    output hkrb_pkg::cmd_t     cmd
);

    hkrb_pkg::state_t state_reg;
    hkrb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hkrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rpt_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            hkrb_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = hkrb_pkg::ST_EXEC;
                end
            end
            hkrb_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = hkrb_pkg::ST_SEND;
            end
            hkrb_pkg::ST_SEND:
            begin
                rpt_valid = 1'b1;
                if (rpt_ready)
                begin
                    state_next = hkrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkrb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/hkrb_dp.sv]
// Datapath: key decode, slot search and the report state registers.
`default_nettype none

module hkrb_dp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire hkrb_pkg::cmd_t cmd,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  key_code,
    output logic             report_sent,
    output logic             accepted,
    output logic [7:0]       modifier_bits,
    output logic [7:0]       slots [hkrb_pkg::NUM_SLOTS],
    output logic             error_flag
);

    logic [1:0] op_reg;
    logic [7:0] code_reg;

    logic [7:0] mods_reg;
    logic [7:0] mods_next;
    logic [7:0] slots_reg [hkrb_pkg::NUM_SLOTS];
    logic [7:0] slots_next [hkrb_pkg::NUM_SLOTS];
    logic       err_reg;
    logic       err_next;
    logic       sent_reg;
    logic       sent_next;
    logic       ok_reg;
    logic       ok_next;

    logic       mapped;
    logic [7:0] usage;
    logic [7:0] mod_bit;
    logic [7:0] entry;
    logic       held;
    logic       any_empty;
    logic [hkrb_pkg::SLOT_IDX_W-1:0] first_empty;

    // Hold the request payload for the update cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            code_reg <= key_code;
        end
    end

    // Decode the key code into a usage and a modifier bit.
    always_comb
    begin
        entry   = hkrb_pkg::ASCII_ROM[code_reg[6:0]];
        mapped  = 1'b1;
        usage   = 8'd0;
        mod_bit = 8'd0;
        priority if (code_reg >= hkrb_pkg::RAW_BASE)
        begin
            usage = code_reg - hkrb_pkg::RAW_BASE;
        end
        else if (code_reg >= hkrb_pkg::MOD_BASE)
        begin
            mod_bit = 8'd1 << code_reg[2:0];
        end
        else
        begin
            mapped  = (entry != 8'd0);
            usage   = entry & hkrb_pkg::USAGE_MASK;
            mod_bit = ((entry & hkrb_pkg::SHIFT_FLAG) != 8'd0) ? hkrb_pkg::LEFT_SHIFT : 8'd0;
        end
    end

    // Compare all slots and pick the lowest empty one.
    always_comb
    begin
        held        = 1'b0;
        any_empty   = 1'b0;
        first_empty = '0;
        for (int i = hkrb_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slots_reg[i] == usage)
            begin
                held = 1'b1;
            end
            if (slots_reg[i] == 8'd0)
            begin
                any_empty   = 1'b1;
                first_empty = hkrb_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        mods_next  = mods_reg;
        slots_next = slots_reg;
        err_next   = err_reg;
        sent_next  = 1'b0;
        ok_next    = 1'b0;
        unique case (hkrb_pkg::opcode_t'(op_reg))
            hkrb_pkg::OP_PRESS:
            begin
                if (!mapped)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    mods_next = mods_reg | mod_bit;
                    if (held)
                    begin
                        sent_next = 1'b1;
                        ok_next   = 1'b1;
                    end
                    else if (any_empty)
                    begin
                        slots_next[first_empty] = usage;
                        sent_next = 1'b1;
                        ok_next   = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            hkrb_pkg::OP_RELEASE:
            begin
                if (mapped)
                begin
                    mods_next = mods_reg & ~mod_bit;
                    for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
                    begin
                        if (usage != 8'd0 && slots_reg[i] == usage)
                        begin
                            slots_next[i] = 8'd0;
                        end
                    end
                    sent_next = 1'b1;
                    ok_next   = 1'b1;
                end
            end
            hkrb_pkg::OP_RELEASE_ALL:
            begin
                mods_next = 8'd0;
                for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
                begin
                    slots_next[i] = 8'd0;
                end
                sent_next = 1'b1;
                ok_next   = 1'b1;
            end
            hkrb_pkg::OP_UNUSED:
            begin
                sent_next = 1'b0;
            end
            default:
            begin
                sent_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= 8'd0;
            err_reg  <= 1'b0;
            sent_reg <= 1'b0;
            ok_reg   <= 1'b0;
            for (int i = 0; i < hkrb_pkg::NUM_SLOTS; i++)
            begin
                slots_reg[i] <= 8'd0;
            end
        end
        else if (cmd.exec)
        begin
            mods_reg  <= mods_next;
            err_reg   <= err_next;
            sent_reg  <= sent_next;
            ok_reg    <= ok_next;
            slots_reg <= slots_next;
        end
    end

    assign report_sent   = sent_reg;
    assign accepted      = ok_reg;
    assign modifier_bits = mods_reg;
    assign slots         = slots_reg;
    assign error_flag    = err_reg;

endmodule

`default_nettype wire

[sv/hkrb_checker.sv]
// Checker: port-level assertions on the report builder, bound to the top level.
`default_nettype none

module hkrb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic report_sent,
    input wire logic accepted,
    input wire logic error_flag
);

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Only one request in flight: no new request right after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // A request is never taken while a response is offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request side open while response pending");

    // Every handled event sends a report, and only those do.
    a_sent_eq_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> report_sent == accepted)
        else $error("report_sent and accepted disagree");

    // The error flag is sticky until reset.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_flag |=> error_flag)
        else $error("error flag cleared without reset");

endmodule

bind hid_keyboard_report_builder_core hkrb_checker u_hkrb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .report_sent (rsp.report_sent),
    .accepted    (rsp.accepted),
    .error_flag  (rsp.error_flag)
);

`default_nettype wire
